>>> sv/stable_priority_task_queue_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the task queue RTL.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_TASK_QUEUE_TOP_MACROS_SVH
`define STABLE_PRIORITY_TASK_QUEUE_TOP_MACROS_SVH

`ifndef ASSERT_OFF

`define SPTQ_ASSERT_NOW(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

`define SPTQ_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`else

`define SPTQ_ASSERT_NOW(label, clk, rst, a, b)

`define SPTQ_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

>>> sv/sptq_pkg.sv
// ----------------------------------------------------------------------------
// sptq_pkg
// Types and constants shared by the task queue cells and top level.
// ----------------------------------------------------------------------------
package sptq_pkg;

   localparam int DEPTH_DEF    = 16;
   localparam int TAG_BITS_DEF = 16;
   localparam int PRI_BITS_DEF = 2;

   typedef enum logic [1:0] {
      KIND_ADD      = 2'd0,
      KIND_TAKE     = 2'd1,
      KIND_COMPLETE = 2'd2,
      KIND_CANCEL   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NOTHING  = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_SHIFT  = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        occ_self;
      logic        occ_right;
   } cell_ctrl_type;

endpackage

>>> sv/sptq_cell.sv
// ----------------------------------------------------------------------------
// sptq_cell
// One slot of the pending list: holds a tag and priority, trades with neighbours.
// ----------------------------------------------------------------------------
module sptq_cell #(
   parameter int TAG_BITS = sptq_pkg::TAG_BITS_DEF,
   parameter int PRI_BITS = sptq_pkg::PRI_BITS_DEF
) (
   input  logic                  clock,
   input  sptq_pkg::cell_ctrl_type ctrl,
   input  logic [TAG_BITS-1:0]   new_tag,
   input  logic [PRI_BITS-1:0]   new_pri,
   input  logic [TAG_BITS-1:0]   head_tag,
   input  logic [PRI_BITS-1:0]   head_pri,
   input  logic [TAG_BITS-1:0]   left_tag,
   input  logic [PRI_BITS-1:0]   left_pri,
   input  logic                  left_keep,
   input  logic [TAG_BITS-1:0]   right_tag,
   input  logic [PRI_BITS-1:0]   right_pri,
   output logic [TAG_BITS-1:0]   tag_out,
   output logic [PRI_BITS-1:0]   pri_out,
   output logic                  keep_out
);
   import sptq_pkg::*;

   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [PRI_BITS-1:0] pri_ff, pri_in;

   // entry stays put on insert when it ranks at or above the new one
   assign keep_out = ctrl.occ_self && (pri_ff >= new_pri);

   always_comb begin
      tag_in = tag_ff;
      pri_in = pri_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (!keep_out) begin
               if (left_keep) begin
                  tag_in = new_tag;
                  pri_in = new_pri;
               end else begin
                  tag_in = left_tag;
                  pri_in = left_pri;
               end
            end
         end
         CELL_SHIFT: begin
            tag_in = right_tag;
            pri_in = right_pri;
         end
         CELL_ROTATE: begin
            if (ctrl.occ_right) begin
               tag_in = right_tag;
               pri_in = right_pri;
            end else if (ctrl.occ_self) begin
               tag_in = head_tag;
               pri_in = head_pri;
            end
         end
         default: begin
            tag_in = tag_ff;
            pri_in = pri_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      pri_ff <= pri_in;
   end

   assign tag_out = tag_ff;
   assign pri_out = pri_ff;

endmodule

>>> sv/stable_priority_task_queue_top.sv
// ----------------------------------------------------------------------------
// stable_priority_task_queue_top
// Priority-ordered task list with take, complete and cancel by tag.
// ----------------------------------------------------------------------------
// Add, take and complete are handled in the cycle the request word is accepted
// and their response word is registered on that edge, so one such item a cycle
// while the response side keeps up. Cancel rotates the whole pending list
// through the head of the cell chain, one entry a cycle, dropping matches as
// they pass: it holds the request side in the rotate and finish states until
// its response word is registered. No request is taken while a response word
// is stalled.
module stable_priority_task_queue_top #(
   parameter int DEPTH    = sptq_pkg::DEPTH_DEF,
   parameter int TAG_BITS = sptq_pkg::TAG_BITS_DEF,
   parameter int PRI_BITS = sptq_pkg::PRI_BITS_DEF,
   localparam int CNT_W   = $clog2(DEPTH + 1),
   localparam int SIZE_W  = $clog2(DEPTH + 2)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_kind,
   input  logic [TAG_BITS-1:0] req_task_tag,
   input  logic [PRI_BITS-1:0] req_task_priority,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [TAG_BITS-1:0] rsp_taken_tag,
   output logic [PRI_BITS-1:0] rsp_taken_priority,
   output logic [CNT_W-1:0]    rsp_pending_count,
   output logic [SIZE_W-1:0]   rsp_queue_size,
   output logic                rsp_queue_empty
);
   import sptq_pkg::*;

`include "stable_priority_task_queue_top_macros.svh"

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_ROTATE = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]    total_ff, total_in;
   logic [CNT_W-1:0]    step_ff, step_in;
   logic                held_ff, held_in;
   logic                found_ff, found_in;
   logic [TAG_BITS-1:0] cancel_tag_ff, cancel_tag_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [TAG_BITS-1:0] rsp_tag_ff, rsp_tag_in;
   logic [PRI_BITS-1:0] rsp_pri_ff, rsp_pri_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [SIZE_W-1:0]   rsp_size_ff, rsp_size_in;
   logic                rsp_empty_ff, rsp_empty_in;

   logic [TAG_BITS-1:0] cell_tag  [DEPTH];
   logic [PRI_BITS-1:0] cell_pri  [DEPTH];
   logic                cell_keep [DEPTH];
   logic [DEPTH-1:0]    occ;

   cell_op_type op;
   logic        rsp_free;
   logic        req_accept;
   logic        head_match;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !rsp_free;
   assign req_accept = req_valid && !req_stall;
   assign head_match = (cell_tag[0] == cancel_tag_ff);

   always_comb begin
      op = CELL_HOLD;
      if (req_accept) begin
         if (req_kind == KIND_ADD && total_ff != CNT_W'(DEPTH)) begin
            op = CELL_INSERT;
         end else if (req_kind == KIND_TAKE && total_ff != '0) begin
            op = CELL_SHIFT;
         end
      end else if (state_ff == ST_ROTATE && step_ff != '0) begin
         op = CELL_ROTATE;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctrl_type       ctrl;
      logic [TAG_BITS-1:0] left_tag, right_tag;
      logic [PRI_BITS-1:0] left_pri, right_pri;
      logic                left_keep;

      assign occ[i] = (CNT_W'(i) < total_ff);

      if (i == 0) begin : g_first
         assign left_tag  = req_task_tag;
         assign left_pri  = req_task_priority;
         assign left_keep = 1'b1;
      end else begin : g_mid
         assign left_tag  = cell_tag[i-1];
         assign left_pri  = cell_pri[i-1];
         assign left_keep = cell_keep[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_tag      = cell_tag[i];
         assign right_pri      = cell_pri[i];
         assign ctrl.occ_right = 1'b0;
      end else begin : g_inner
         assign right_tag      = cell_tag[i+1];
         assign right_pri      = cell_pri[i+1];
         assign ctrl.occ_right = occ[i+1];
      end

      assign ctrl.op       = op;
      assign ctrl.occ_self = occ[i];

      sptq_cell #(
         .TAG_BITS (TAG_BITS),
         .PRI_BITS (PRI_BITS)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .new_tag   (req_task_tag),
         .new_pri   (req_task_priority),
         .head_tag  (cell_tag[0]),
         .head_pri  (cell_pri[0]),
         .left_tag  (left_tag),
         .left_pri  (left_pri),
         .left_keep (left_keep),
         .right_tag (right_tag),
         .right_pri (right_pri),
         .tag_out   (cell_tag[i]),
         .pri_out   (cell_pri[i]),
         .keep_out  (cell_keep[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      step_in       = step_ff;
      held_in       = held_ff;
      found_in      = found_ff;
      cancel_tag_in = cancel_tag_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_pri_in    = rsp_pri_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_empty_in  = rsp_empty_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_tag_in    = '0;
               rsp_pri_in    = '0;
               case (req_kind)
                  KIND_ADD: begin
                     if (total_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        total_in = total_ff + 1'b1;
                     end
                  end
                  KIND_TAKE: begin
                     if (total_ff == '0) begin
                        rsp_status_in = STAT_NOTHING;
                     end else begin
                        rsp_tag_in = cell_tag[0];
                        rsp_pri_in = cell_pri[0];
                        total_in   = total_ff - 1'b1;
                        held_in    = 1'b1;
                     end
                  end
                  KIND_COMPLETE: begin
                     if (held_ff) begin
                        held_in = 1'b0;
                     end else begin
                        rsp_status_in = STAT_NOTHING;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b0;
                     cancel_tag_in = req_task_tag;
                     step_in       = total_ff;
                     found_in      = 1'b0;
                     state_in      = ST_ROTATE;
                  end
               endcase
            end
         end
         ST_ROTATE: begin
            if (step_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff - 1'b1;
               if (head_match) begin
                  total_in = total_ff - 1'b1;
                  found_in = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = found_ff ? STAT_OK : STAT_NOTFOUND;
               rsp_tag_in    = '0;
               rsp_pri_in    = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_valid_in && !(rsp_valid_ff && rsp_stall)) begin
         rsp_count_in = total_in;
         rsp_size_in  = SIZE_W'(total_in) + SIZE_W'(held_in);
         rsp_empty_in = (total_in == '0) && !held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         step_ff      <= '0;
         held_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         step_ff      <= step_in;
         held_ff      <= held_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cancel_tag_ff <= cancel_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_pri_ff    <= rsp_pri_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_taken_tag      = rsp_tag_ff;
   assign rsp_taken_priority = rsp_pri_ff;
   assign rsp_pending_count  = rsp_count_ff;
   assign rsp_queue_size     = rsp_size_ff;
   assign rsp_queue_empty    = rsp_empty_ff;

   `SPTQ_ASSERT_NOW(a_total_range, clock, reset, 1'b1, total_ff <= CNT_W'(DEPTH))
   `SPTQ_ASSERT_NOW(a_step_range, clock, reset, state_ff == ST_ROTATE, step_ff <= total_ff)
   `SPTQ_ASSERT_NEXT(a_rotate_no_grow, clock, reset, state_ff == ST_ROTATE, total_ff <= $past(total_ff))
   `SPTQ_ASSERT_NEXT(a_cancel_enters, clock, reset, req_accept && req_kind == KIND_CANCEL, state_ff == ST_ROTATE)
   `SPTQ_ASSERT_NEXT(a_finish_responds, clock, reset, state_ff == ST_FINISH && rsp_free, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stable_priority_task_queue_top. A queued driver
// sends add, take, complete and cancel words in bursts with random gaps. A
// monitor checks each response word against a priority-list predictor,
// while the response side stalls on its own shifting pattern.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sptq_pkg::*;

   localparam int LIST_DEPTH  = DEPTH_DEF;
   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 40;

   typedef struct {
      kind_type                kind;
      logic [TAG_BITS_DEF-1:0] tag;
      logic [PRI_BITS_DEF-1:0] pri;
      bit                      pause;
   } cmd_word_type;

   typedef struct {
      status_type              status;
      logic [TAG_BITS_DEF-1:0] tag;
      logic [PRI_BITS_DEF-1:0] pri;
      logic [4:0]              pending;
      logic [4:0]              size;
      logic                    empty;
   } queue_rsp_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_kind = KIND_ADD;
   logic [TAG_BITS_DEF-1:0] req_task_tag = '0;
   logic [PRI_BITS_DEF-1:0] req_task_priority = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [1:0]              rsp_status;
   logic [TAG_BITS_DEF-1:0] rsp_taken_tag;
   logic [PRI_BITS_DEF-1:0] rsp_taken_priority;
   logic [4:0]              rsp_pending_count;
   logic [4:0]              rsp_queue_size;
   logic                    rsp_queue_empty;

   cmd_word_type  cmd_q[$];
   queue_rsp_type rsp_expect_q[$];
   cmd_word_type  on_wire;
   queue_rsp_type want;

   // predictor state
   logic [TAG_BITS_DEF-1:0] list_tag[LIST_DEPTH];
   logic [PRI_BITS_DEF-1:0] list_pri[LIST_DEPTH];
   int                      list_count = 0;
   logic [TAG_BITS_DEF-1:0] held_tag = '0;
   logic                    held = 1'b0;

   int   fail_count = 0;
   int   idle_cycles = 0;
   int   burst_left = 0;
   int   gap_left = 0;
   logic next_valid;
   int   stall_tick = 0;
   int   stall_mode = 0;

   always #5 clock = ~clock;

   stable_priority_task_queue_top DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_task_tag       (req_task_tag),
      .req_task_priority  (req_task_priority),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_taken_tag      (rsp_taken_tag),
      .rsp_taken_priority (rsp_taken_priority),
      .rsp_pending_count  (rsp_pending_count),
      .rsp_queue_size     (rsp_queue_size),
      .rsp_queue_empty    (rsp_queue_empty)
   );

   function automatic queue_rsp_type queue_apply(input cmd_word_type w);
      queue_rsp_type r;
      int            pos;
      int            kept;
      int            k;
      int            total;
      r.status = STAT_OK;
      r.tag    = '0;
      r.pri    = '0;
      case (w.kind)
         KIND_ADD: begin
            if (list_count >= LIST_DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               pos = 0;
               while (pos < list_count && list_pri[pos] >= w.pri) pos++;
               for (k = list_count; k > pos; k--) begin
                  list_tag[k] = list_tag[k-1];
                  list_pri[k] = list_pri[k-1];
               end
               list_tag[pos] = w.tag;
               list_pri[pos] = w.pri;
               list_count++;
            end
         end
         KIND_TAKE: begin
            if (list_count == 0) begin
               r.status = STAT_NOTHING;
            end else begin
               r.tag    = list_tag[0];
               r.pri    = list_pri[0];
               held_tag = list_tag[0];
               held     = 1'b1;
               for (k = 1; k < list_count; k++) begin
                  list_tag[k-1] = list_tag[k];
                  list_pri[k-1] = list_pri[k];
               end
               list_count--;
            end
         end
         KIND_COMPLETE: begin
            if (held) begin
               held     = 1'b0;
               held_tag = '0;
            end else begin
               r.status = STAT_NOTHING;
            end
         end
         default: begin
            kept = 0;
            for (k = 0; k < list_count; k++) begin
               if (list_tag[k] != w.tag) begin
                  list_tag[kept] = list_tag[k];
                  list_pri[kept] = list_pri[k];
                  kept++;
               end
            end
            if (kept == list_count) r.status = STAT_NOTFOUND;
            list_count = kept;
         end
      endcase
      total     = list_count + (held ? 1 : 0);
      r.pending = list_count[4:0];
      r.size    = total[4:0];
      r.empty   = (total == 0);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         fail_count++;
      end
   endtask

   task automatic push_cmd(input kind_type kind, input int tag, input int pri,
                           input bit pause = 1'b0);
      cmd_word_type w;
      w.kind  = kind;
      w.tag   = tag[TAG_BITS_DEF-1:0];
      w.pri   = pri[PRI_BITS_DEF-1:0];
      w.pause = pause;
      cmd_q   = {cmd_q, w};
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) rsp_expect_q = {rsp_expect_q, queue_apply(on_wire)};
         if (!req_valid || !req_stall) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (cmd_q.size() != 0) begin
               if (cmd_q[0].pause) begin
                  if (rsp_expect_q.size() == 0) cmd_q.delete(0);
               end else begin
                  on_wire    = cmd_q[0];
                  cmd_q.delete(0);
                  next_valid = 1'b1;
                  req_kind          <= on_wire.kind;
                  req_task_tag      <= on_wire.tag;
                  req_task_priority <= on_wire.pri;
                  if (burst_left > 1) begin
                     burst_left--;
                  end else begin
                     burst_left = $urandom_range(1, 30);
                     gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                  end
               end
            end
            req_valid <= next_valid;
         end
      end
   end

   // response side stall pattern
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 150 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (stall_tick[2:0] < 3);
      endcase
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_expect_q.size() == 0) begin
            $error("response word with nothing expected");
            fail_count++;
         end else begin
            want = rsp_expect_q[0];
            rsp_expect_q.delete(0);
            check_field("status", want.status, rsp_status);
            check_field("taken_tag", want.tag, rsp_taken_tag);
            check_field("taken_priority", want.pri, rsp_taken_priority);
            check_field("pending_count", want.pending, rsp_pending_count);
            check_field("queue_size", want.size, rsp_queue_size);
            check_field("queue_empty", want.empty, rsp_queue_empty);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("stable_priority_task_queue_top verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int       ph;
      int       n;
      int       k;
      int       mode;
      int       roll;
      int       tag;
      int       tag_pool[8];
      kind_type kind;

      // empty list and nothing held
      push_cmd(KIND_COMPLETE, 16'h0000, 0);
      push_cmd(KIND_TAKE, 16'hFFFF, 3);
      push_cmd(KIND_CANCEL, 16'hFFFF, 0);
      // ordering, equal priority kept first in first out
      push_cmd(KIND_ADD, 16'hFFFF, 3);
      push_cmd(KIND_ADD, 16'h0000, 0);
      push_cmd(KIND_ADD, 16'hAAAA, 1);
      push_cmd(KIND_ADD, 16'h5555, 3);
      push_cmd(KIND_TAKE, 16'h0000, 0);
      push_cmd(KIND_TAKE, 16'h0000, 0);
      push_cmd(KIND_COMPLETE, 16'hFFFF, 3);
      push_cmd(KIND_CANCEL, 16'hAAAA, 0);
      push_cmd(KIND_CANCEL, 16'hAAAA, 0);
      push_cmd(KIND_TAKE, 16'h0000, 0);
      // fill to the brim, then overflow and a multi-match cancel
      for (k = 0; k < LIST_DEPTH; k++)
         push_cmd(KIND_ADD, (k % 3 == 0) ? 16'h5555 : $urandom_range(0, 65535), k % 4);
      push_cmd(KIND_ADD, 16'h1234, 2);
      push_cmd(KIND_CANCEL, 16'h5555, 1);
      push_cmd(KIND_ADD, 0, 0, 1'b1);

      for (ph = 0; ph < 20; ph++) begin
         mode = $urandom_range(0, 2);
         for (k = 0; k < 8; k++) tag_pool[k] = $urandom_range(0, 65535);
         for (n = 0; n < 50; n++) begin
            roll = $urandom_range(0, 99);
            tag  = ($urandom_range(0, 4) != 0) ? tag_pool[$urandom_range(0, 7)]
                                                : $urandom_range(0, 65535);
            if (mode == 0) begin
               if (roll < 70)      kind = KIND_ADD;
               else if (roll < 85) kind = KIND_TAKE;
               else if (roll < 95) kind = KIND_CANCEL;
               else                kind = KIND_COMPLETE;
            end else if (mode == 1) begin
               if (roll < 20)      kind = KIND_ADD;
               else if (roll < 60) kind = KIND_TAKE;
               else if (roll < 80) kind = KIND_COMPLETE;
               else                kind = KIND_CANCEL;
            end else begin
               if (roll < 35)      kind = KIND_ADD;
               else if (roll < 60) kind = KIND_TAKE;
               else if (roll < 80) kind = KIND_CANCEL;
               else                kind = KIND_COMPLETE;
            end
            push_cmd(kind, tag, $urandom_range(0, 3));
         end
         if (ph % 4 == 3) push_cmd(KIND_ADD, 0, 0, 1'b1);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (cmd_q.size() != 0 || req_valid || rsp_expect_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && rsp_expect_q.size() == 0) begin
         $display("stable_priority_task_queue_top verification clean");
      end else begin
         $display("stable_priority_task_queue_top verification failed");
      end
      $finish;
   end

endmodule

>>> stable_priority_task_queue_top.f
+incdir+sv
sv/sptq_pkg.sv
sv/sptq_cell.sv
sv/stable_priority_task_queue_top.sv
verif/tb.sv
